/* rtl/lwsd_pkg.sv */
// Shared types, constants and the segment decoder for the load weight display block.
`default_nettype none

package lwsd_pkg;

  // Field widths
  localparam int TARE_W     = 24;
  localparam int SCALE_W    = 32;
  localparam int GRAMS_W    = 31;
  localparam int SEG_W      = 7;
  localparam int K_W        = 18;
  localparam int CFG_ADDR_W = 1;

  // Result packing on the output stream
  localparam int OUT_FIELDS_W = GRAMS_W + 1 + 4 * SEG_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TARE  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd256;

  // 1000 g/kg times 256 for the Q24.8 factor
  localparam logic [K_W-1:0] GRAMS_PER_KG_Q8 = 18'd256000;

  localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;

  // Sideband that rides with each item down the pipe
  typedef struct packed {
    logic valid;
    logic neg;
  } lwsd_ctl_t;

  // One result item, magnitude_grams in the lowest bits
  typedef struct packed {
    logic [SEG_W-1:0]   segment_fourth;
    logic [SEG_W-1:0]   segment_third;
    logic [SEG_W-1:0]   segment_second;
    logic [SEG_W-1:0]   segment_first;
    logic               is_negative;
    logic [GRAMS_W-1:0] magnitude_grams;
  } lwsd_result_t;

  // Decimal digit to segment code, bit0 is segment a
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    unique case (digit)
      4'd0:    code = 7'h3F;
      4'd1:    code = 7'h06;
      4'd2:    code = 7'h5B;
      4'd3:    code = 7'h4F;
      4'd4:    code = 7'h66;
      4'd5:    code = 7'h6D;
      4'd6:    code = 7'h7D;
      4'd7:    code = 7'h07;
      4'd8:    code = 7'h7F;
      4'd9:    code = 7'h6F;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/lwsd_div.sv */
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
`default_nettype none

module lwsd_div #(
  parameter int NUM_W = 42
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire lwsd_pkg::lwsd_ctl_t           ctl_i,
  input  wire logic [NUM_W-1:0]              num_i,
  input  wire logic [lwsd_pkg::SCALE_W-1:0]  den_i,
  output lwsd_pkg::lwsd_ctl_t                ctl_o,
  output logic [lwsd_pkg::GRAMS_W-1:0]       quo_o
);
  import lwsd_pkg::*;

  localparam int QW = GRAMS_W;
  localparam int RW = (NUM_W > SCALE_W + QW) ? NUM_W : SCALE_W + QW;

  lwsd_ctl_t       ctl_r [0:QW];
  logic            sat_r [0:QW];
  logic [RW-1:0]   rem_r [0:QW-1];
  logic [QW-1:0]   quo_r [1:QW];

  // Entry stage: quotient overflows the field when num >= den * 2^QW
  // (a zero divisor always lands here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= RW'(num_i) >= (RW'(den_i) << QW);
      rem_r[0] <= RW'(num_i);
    end
  end

  // One trial subtraction per stage, MSB of the quotient first
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [RW:0] trial;
    logic        take;

    assign trial = (RW + 1)'(rem_r[k]) - ((RW + 1)'(den_i) << B);
    assign take  = !trial[RW];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sat_r[k+1] <= sat_r[k];
      end
    end

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          quo_r[1] <= QW'(take);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          quo_r[k+1] <= {quo_r[k][QW-2:0], take};
        end
      end
    end

    // final remainder is not needed
    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= take ? trial[RW-1:0] : rem_r[k];
        end
      end
    end
  end

  assign ctl_o = ctl_r[QW];
  assign quo_o = sat_r[QW] ? {QW{1'b1}} : quo_r[QW];

endmodule

`default_nettype wire

/* rtl/lwsd_digits.sv */
// Four-stage split of the low four decimal digits of grams into segment codes.
`default_nettype none

module lwsd_digits (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire lwsd_pkg::lwsd_ctl_t           ctl_i,
  input  wire logic [lwsd_pkg::GRAMS_W-1:0]  grams_i,
  output logic                               valid_o,
  output lwsd_pkg::lwsd_result_t             res_o
);
  import lwsd_pkg::*;

  // Reciprocals: floor(x * M / 2^S) is exact over the input range
  localparam logic [31:0] RECIP_10K  = 32'd3518437209;
  localparam int          SHIFT_10K  = 45;
  localparam logic [13:0] RECIP_1000 = 14'd8389;
  localparam logic [13:0] RECIP_100  = 14'd10486;
  localparam logic [13:0] RECIP_10   = 14'd13108;
  localparam logic [13:0] TEN_K      = 14'd10000;

  lwsd_ctl_t          ctl1_r, ctl2_r, ctl3_r;
  logic               valid_r;
  logic [62:0]        prod1_r;
  logic [GRAMS_W-1:0] grams1_r, grams2_r, grams3_r;
  logic [13:0]        rem2_r, rem3_r;
  logic               lt2_r, lt3_r;
  logic [3:0]         th3_r;
  logic [6:0]         hu3_r;
  logic [9:0]         te3_r;
  lwsd_result_t       res_r;

  logic [17:0] q10k;
  logic [31:0] q10k_scaled;
  logic [13:0] rem2_nxt;
  logic [27:0] p_th, p_hu, p_te;
  logic [6:0]  hu_dig;
  logic [9:0]  te_dig;
  logic [13:0] un_dig;
  lwsd_result_t res_nxt;

  // Valid and sign travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r  <= '0;
      ctl2_r  <= '0;
      ctl3_r  <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      ctl1_r  <= ctl_i;
      ctl2_r  <= ctl1_r;
      ctl3_r  <= ctl2_r;
      valid_r <= ctl3_r.valid;
    end
  end

  // Stage 2: remainder modulo 10000 and the under-10000 flag
  always_comb begin
    q10k        = prod1_r[SHIFT_10K +: 18];
    q10k_scaled = 32'(q10k) * 32'(TEN_K);
    rem2_nxt    = 14'(32'(grams1_r) - q10k_scaled);
  end

  // Stage 3: thousands, hundreds and tens quotients
  always_comb begin
    p_th = 28'(rem2_r) * 28'(RECIP_1000);
    p_hu = 28'(rem2_r) * 28'(RECIP_100);
    p_te = 28'(rem2_r) * 28'(RECIP_10);
  end

  // Stage 4: each digit is its quotient less ten times the next one up
  always_comb begin
    hu_dig = hu3_r - 7'(7'(th3_r) * 7'd10);
    te_dig = te3_r - 10'(10'(hu3_r) * 10'd10);
    un_dig = rem3_r - 14'(14'(te3_r) * 14'd10);

    res_nxt.magnitude_grams = grams3_r;
    res_nxt.is_negative     = ctl3_r.neg;
    res_nxt.segment_first   = (ctl3_r.neg && lt3_r) ? SEG_MINUS : seg_code(th3_r);
    res_nxt.segment_second  = seg_code(hu_dig[3:0]);
    res_nxt.segment_third   = seg_code(te_dig[3:0]);
    res_nxt.segment_fourth  = seg_code(un_dig[3:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r  <= 63'(grams_i) * 63'(RECIP_10K);
      grams1_r <= grams_i;

      rem2_r   <= rem2_nxt;
      lt2_r    <= (q10k == '0);
      grams2_r <= grams1_r;

      th3_r    <= p_th[26:23];
      hu3_r    <= p_hu[26:20];
      te3_r    <= p_te[26:17];
      rem3_r   <= rem2_r;
      lt3_r    <= lt2_r;
      grams3_r <= grams2_r;

      res_r    <= res_nxt;
    end
  end

  assign valid_o = valid_r;
  assign res_o   = res_r;

endmodule

`default_nettype wire

/* rtl/load_weight_to_segment_display.sv */
// Top level: tare-corrected load-cell sample to grams and four seven-segment codes.
//
// Input stream: one signed sample per item in in_tdata, accepted when
// in_tvalid and in_tready are both high. Output stream: one result per
// sample, grams, sign flag and four segment codes packed in out_tdata.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 tare,
// 1 counts per kg in Q24.8); write only while no item is in flight.
// Depth: 40 register stages (3 front stages, 32 divider stages, 4 digit
// stages, 1 output register). Throughput: one item per cycle while the
// pipe is not held; the divider's one quotient bit per stage sets the depth.
// When the receiver stalls, the output register holds its item and one
// more item lands in a skid register; in_tready then drops and the whole
// pipe holds until the skid drains. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipe, sets tare to 0 and the
// scale factor to 256.
`default_nettype none

module load_weight_to_segment_display #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: raw_sample [SAMPLE_BITS-1:0], zero pad above
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,
  // out_tdata: magnitude_grams [30:0], is_negative [31], segment_first [38:32],
  // segment_second [45:39], segment_third [52:46], segment_fourth [59:53], zero pad
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [lwsd_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [lwsd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [lwsd_pkg::SCALE_W-1:0]      cfg_wdata
);
  import lwsd_pkg::*;

  localparam int DIFF_W = ((SAMPLE_BITS > TARE_W) ? SAMPLE_BITS : TARE_W) + 1;
  localparam int MAG_W  = DIFF_W - 1;
  localparam int NUM_W  = MAG_W + K_W;

  logic [TARE_W-1:0]  tare_r;
  logic [SCALE_W-1:0] scale_r;

  logic                     en;
  logic                     s1_valid_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [DIFF_W-1:0] diff_nxt;
  lwsd_ctl_t                ctl2_r, ctl3_r;
  logic [MAG_W-1:0]         mag_r;
  logic [DIFF_W-1:0]        mag_nxt;
  logic [NUM_W-1:0]         num_r;

  lwsd_ctl_t          div_ctl;
  logic [GRAMS_W-1:0] div_quo;
  logic               dig_valid;
  lwsd_result_t       dig_res;
  logic               push;

  logic         out_valid_r, skid_valid_r;
  lwsd_result_t out_data_r, skid_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tare_r  <= '0;
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TARE:  tare_r  <= cfg_wdata[TARE_W-1:0];
        REG_SCALE: scale_r <= cfg_wdata;
      endcase
    end
  end

  // Pipe advances whenever the skid register is free
  assign en        = !skid_valid_r;
  assign in_tready = en;

  // Front stages: signed difference, magnitude, scale by 256000
  assign diff_nxt = DIFF_W'($signed(in_tdata[SAMPLE_BITS-1:0])) - DIFF_W'($signed(tare_r));
  assign mag_nxt  = diff_r[DIFF_W-1] ? -diff_r : diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      ctl2_r     <= '0;
      ctl3_r     <= '0;
    end else if (en) begin
      s1_valid_r   <= in_tvalid;
      ctl2_r.valid <= s1_valid_r;
      ctl2_r.neg   <= diff_r[DIFF_W-1];
      ctl3_r       <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      mag_r  <= mag_nxt[MAG_W-1:0];
      num_r  <= NUM_W'(mag_r) * NUM_W'(GRAMS_PER_KG_Q8);
    end
  end

  lwsd_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (ctl3_r),
    .num_i (num_r),
    .den_i (scale_r),
    .ctl_o (div_ctl),
    .quo_o (div_quo)
  );

  lwsd_digits u_digits (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (div_ctl),
    .grams_i (div_quo),
    .valid_o (dig_valid),
    .res_o   (dig_res)
  );

  // Output register with one-item skid
  assign push = en && dig_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= dig_res;
      end
    end else if (push) begin
      skid_data_r <= dig_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_data_r};

endmodule

`default_nettype wire
